@@ rtl/rcm_pkg.sv @@
// Types and constants shared by the region change monitor.
// Holds the CRC-32 constants, the search sequence, status codes and FSM states.
// No dependencies.
`default_nettype none

package rcm_pkg;

   localparam int FIELD_W = 48;
   localparam int PROT_W = 32;
   localparam int CRC_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   // first eight bytes of the 65 48 8B 04 25 60 00 00 00 sequence, oldest in the top byte
   localparam logic [63:0] SEQ_HEAD = 64'h6548_8B04_2560_0000;
   localparam logic [7:0] SEQ_TAIL = 8'h00;

   localparam logic [PROT_W-1:0] EXEC_MASK_RESET = 32'h0000_00F0;

   // register index, taken from the word address bit
   localparam logic CSR_EXEC_MASK_IDX = 1'b0;

   typedef enum logic {
      CMD_DATA = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_NEW = 2'd0,
      STAT_DATA_CHANGED = 2'd1,
      STAT_PROT_CHANGED = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CRC = 5'b00010,
      S_SCAN = 5'b00100,
      S_DRAIN = 5'b01000,
      S_DECIDE = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/region_change_monitor.sv @@
// Region change monitor: sequencer, bit-serial CRC-32 unit, history table memory.
// Depends on rcm_pkg.
//
// Usage: region bytes arrive on the req_ channel, one transaction per byte, each
// carrying the region's base, size, protection and commit flag; req_last_byte
// marks the end of a region. A transaction with req_cmd = clear empties the
// history table. Bytes of uncommitted regions, or of regions whose protection
// shares no bit with exec_mask, are dropped. A handled byte is taken, then runs
// through the single shift/xor CRC unit, one bit per cycle. A last byte then
// sweeps the history table through its one read port, one entry per cycle,
// then passes a drain state to a decision that waits while the result register
// is held by rsp_stall. req_stall is high while a transaction is in work.
// One rsp_ transaction leaves per changed, new or full-table region; unchanged
// regions give none. The result sits in an output register; new bytes are taken
// while it waits, and only the table decision waits for rsp_stall to drop.
// Reset clears the sequencer and the valid bits of all entries and sets exec_mask
// to 0xF0 at once; no clearing pass is needed. exec_mask is written through the
// csr_ port at byte addresses 0 to 3.
`default_nettype none

module region_change_monitor #(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDR_BITS = 48
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_cmd,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic [rcm_pkg::FIELD_W-1:0]         req_region_base,
   input  wire logic [rcm_pkg::FIELD_W-1:0]         req_region_size,
   input  wire logic [rcm_pkg::PROT_W-1:0]          req_protection,
   input  wire logic                                req_committed,
   input  wire logic                                req_last_byte,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [rcm_pkg::FIELD_W-1:0]              rsp_report_base,
   output logic [rcm_pkg::FIELD_W-1:0]              rsp_report_size,
   output logic [rcm_pkg::CRC_W-1:0]                rsp_region_crc,
   output logic [rcm_pkg::PROT_W-1:0]               rsp_old_protection,
   output logic                                     rsp_pattern_found,
   output logic                                     rsp_table_full,
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rcm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [rcm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rcm_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);
   import rcm_pkg::*;

   localparam int KEY_W = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [KEY_W-1:0]  base;
      logic [KEY_W-1:0]  size;
      logic [CRC_W-1:0]  crc;
      logic [PROT_W-1:0] prot;
   } entry_type;

   // configuration
   logic [PROT_W-1:0] exec_mask_ff;
   logic              csr_write;

   // sequencer and scan state
   state_type         state_ff;
   logic [2:0]        bit_cnt_ff;
   logic [CRC_W-1:0]  crc_ff;
   logic [63:0]       window_ff;
   logic [3:0]        fill_ff;
   logic              pattern_ff;
   logic              at_start_ff;

   // item being worked on
   logic [KEY_W-1:0]  cur_base_ff;
   logic [KEY_W-1:0]  cur_size_ff;
   logic [PROT_W-1:0] cur_prot_ff;
   logic              cur_last_ff;

   // table and sweep
   entry_type                  table_mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]   valid_ff;
   entry_type                  rd_data_ff;
   logic [IDX_W-1:0]           scan_idx_ff;
   logic [IDX_W-1:0]           cmp_idx_ff;
   logic                       cmp_en_ff;
   logic                       hit_found_ff;
   logic [IDX_W-1:0]           hit_idx_ff;
   logic [CRC_W-1:0]           hit_crc_ff;
   logic [PROT_W-1:0]          hit_prot_ff;
   logic                       free_found_ff;
   logic [IDX_W-1:0]           free_idx_ff;

   // result register
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [KEY_W-1:0]  rsp_base_ff;
   logic [KEY_W-1:0]  rsp_size_ff;
   logic [CRC_W-1:0]  rsp_crc_ff;
   logic [PROT_W-1:0] rsp_old_prot_ff;
   logic              rsp_pattern_ff;
   logic              rsp_full_ff;

   // accept-side logic
   logic              req_take;
   logic              take_clear;
   logic              take_byte;
   logic              qualified;
   logic [CRC_W-1:0]  crc_seed;
   logic [63:0]       win_base;
   logic [3:0]        fill_base;
   logic              pattern_base;
   logic              seq_match;
   logic [CRC_W-1:0]  crc_step;

   // decision logic
   logic              out_busy;
   logic              decide_go;
   logic [CRC_W-1:0]  crc_final;
   status_type        dec_status;
   logic              dec_emit;
   logic              dec_write;
   logic [IDX_W-1:0]  dec_widx;
   logic              dec_full;
   logic [PROT_W-1:0] dec_old_prot;
   entry_type         dec_entry;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == CSR_EXEC_MASK_IDX);
   assign csr_prdata = (csr_paddr[2] == CSR_EXEC_MASK_IDX) ? exec_mask_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_mask_ff <= EXEC_MASK_RESET;
      end else if (csr_write) begin
         exec_mask_ff <= csr_pwdata;
      end
   end

   // ---------------- accept side ----------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign take_clear = req_take && (req_cmd == CMD_CLEAR);
   assign qualified = req_committed && ((req_protection & exec_mask_ff) != '0);
   assign take_byte = req_take && (req_cmd == CMD_DATA) && qualified;

   // restart CRC, window and pattern flag on the first byte of a region
   assign crc_seed = at_start_ff ? CRC_INIT : crc_ff;
   assign win_base = at_start_ff ? '0 : window_ff;
   assign fill_base = at_start_ff ? '0 : fill_ff;
   assign pattern_base = at_start_ff ? 1'b0 : pattern_ff;
   assign seq_match = fill_base[3] && (win_base == SEQ_HEAD) &&
                      (req_data_byte == SEQ_TAIL);

   // shared CRC unit: one reflected bit per cycle
   assign crc_step = (crc_ff >> 1) ^ (CRC_POLY & {CRC_W{crc_ff[0]}});

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bit_cnt_ff <= '0;
         crc_ff <= CRC_INIT;
         window_ff <= '0;
         fill_ff <= '0;
         pattern_ff <= 1'b0;
         at_start_ff <= 1'b1;
         scan_idx_ff <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= (state_ff == S_SCAN);
         case (state_ff)
            S_IDLE: begin
               if (take_byte) begin
                  pattern_ff <= pattern_base | seq_match;
                  window_ff <= {win_base[55:0], req_data_byte};
                  fill_ff <= fill_base[3] ? fill_base : fill_base + 4'd1;
                  crc_ff <= crc_seed ^ {24'd0, req_data_byte};
                  at_start_ff <= req_last_byte;
                  bit_cnt_ff <= '0;
                  state_ff <= S_CRC;
               end
            end
            S_CRC: begin
               crc_ff <= crc_step;
               bit_cnt_ff <= bit_cnt_ff + 3'd1;
               if (bit_cnt_ff == 3'd7) begin
                  scan_idx_ff <= '0;
                  state_ff <= cur_last_ff ? S_SCAN : S_IDLE;
               end
            end
            S_SCAN: begin
               if (scan_idx_ff == LAST_IDX) begin
                  state_ff <= S_DRAIN;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (decide_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // hold the item fields for the sweep and the result
   always_ff @(posedge clock) begin
      if (take_byte) begin
         cur_base_ff <= req_region_base[KEY_W-1:0];
         cur_size_ff <= req_region_size[KEY_W-1:0];
         cur_prot_ff <= req_protection;
         cur_last_ff <= req_last_byte;
      end
   end

   // ---------------- table sweep ----------------
   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem_ff[scan_idx_ff];
      cmp_idx_ff <= scan_idx_ff;
      if (dec_write) begin
         table_mem_ff[dec_widx] <= dec_entry;
      end
   end

   // first valid entry with a matching key, first free entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (state_ff == S_CRC) begin
         hit_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmp_en_ff) begin
         if (valid_ff[cmp_idx_ff]) begin
            if (!hit_found_ff && (rd_data_ff.base == cur_base_ff) &&
                (rd_data_ff.size == cur_size_ff)) begin
               hit_found_ff <= 1'b1;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en_ff) begin
         if (valid_ff[cmp_idx_ff]) begin
            if (!hit_found_ff && (rd_data_ff.base == cur_base_ff) &&
                (rd_data_ff.size == cur_size_ff)) begin
               hit_idx_ff <= cmp_idx_ff;
               hit_crc_ff <= rd_data_ff.crc;
               hit_prot_ff <= rd_data_ff.prot;
            end
         end else if (!free_found_ff) begin
            free_idx_ff <= cmp_idx_ff;
         end
      end
   end

   // ---------------- decision ----------------
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign decide_go = (state_ff == S_DECIDE) && !out_busy;
   assign crc_final = ~crc_ff;

   always_comb begin
      dec_status = STAT_NEW;
      dec_emit = 1'b1;
      dec_full = 1'b0;
      dec_old_prot = '0;
      dec_widx = free_idx_ff;
      if (hit_found_ff) begin
         dec_widx = hit_idx_ff;
         dec_old_prot = hit_prot_ff;
         if (hit_prot_ff != cur_prot_ff) begin
            dec_status = STAT_PROT_CHANGED;
         end else if (hit_crc_ff != crc_final) begin
            dec_status = STAT_DATA_CHANGED;
         end else begin
            dec_emit = 1'b0;
         end
      end else if (!free_found_ff) begin
         dec_full = 1'b1;
      end
   end

   assign dec_write = decide_go && dec_emit && !dec_full;
   assign dec_entry = '{base: cur_base_ff, size: cur_size_ff,
                        crc: crc_final, prot: cur_prot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (take_clear) begin
         valid_ff <= '0;
      end else if (dec_write) begin
         valid_ff[dec_widx] <= 1'b1;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (decide_go && dec_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_go && dec_emit) begin
         rsp_status_ff <= dec_status;
         rsp_base_ff <= cur_base_ff;
         rsp_size_ff <= cur_size_ff;
         rsp_crc_ff <= crc_final;
         rsp_old_prot_ff <= dec_old_prot;
         rsp_pattern_ff <= pattern_ff;
         rsp_full_ff <= dec_full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_report_base = FIELD_W'(rsp_base_ff);
   assign rsp_report_size = FIELD_W'(rsp_size_ff);
   assign rsp_region_crc = rsp_crc_ff;
   assign rsp_old_protection = rsp_old_prot_ff;
   assign rsp_pattern_found = rsp_pattern_ff;
   assign rsp_table_full = rsp_full_ff;

`ifndef SYNTHESIS
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DECIDE))
      else $error("result raised outside the table decision");

   a_full_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_full_ff || rsp_status_ff == STAT_NEW))
      else $error("table full flagged on a known region");

   a_hit_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && hit_found_ff) |-> valid_ff[hit_idx_ff])
      else $error("matched entry is not valid");

   a_no_overwrite_free: assert property (@(posedge clock) disable iff (reset)
      (dec_write && !hit_found_ff) |-> !valid_ff[dec_widx])
      else $error("new region written over a valid entry");
`endif

endmodule

`default_nettype wire

@@ bench/rcm_checker.sv @@
// Scoreboard for the region change monitor: tracks exec_mask writes, predicts reports
// from accepted byte transactions and compares them with the rsp_ channel.
// Depends on rcm_pkg.
module rcm_checker #(
   parameter int TABLE_ENTRIES = 64,
   parameter int ADDR_BITS = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_data_byte,
   input  logic [rcm_pkg::FIELD_W-1:0]    req_region_base,
   input  logic [rcm_pkg::FIELD_W-1:0]    req_region_size,
   input  logic [rcm_pkg::PROT_W-1:0]     req_protection,
   input  logic                           req_committed,
   input  logic                           req_last_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [rcm_pkg::FIELD_W-1:0]    rsp_report_base,
   input  logic [rcm_pkg::FIELD_W-1:0]    rsp_report_size,
   input  logic [rcm_pkg::CRC_W-1:0]      rsp_region_crc,
   input  logic [rcm_pkg::PROT_W-1:0]     rsp_old_protection,
   input  logic                           rsp_pattern_found,
   input  logic                           rsp_table_full,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rcm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rcm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatches,
   output int                             expected_left,
   output int                             results_checked
);
   import rcm_pkg::*;

   localparam logic [FIELD_W-1:0] KEY_MASK =
      (ADDR_BITS >= FIELD_W) ? '1 : ((FIELD_W'(1) << ADDR_BITS) - FIELD_W'(1));

   typedef struct {
      status_type          status;
      logic [FIELD_W-1:0]  base;
      logic [FIELD_W-1:0]  size;
      logic [CRC_W-1:0]    crc;
      logic [PROT_W-1:0]   old_prot;
      logic                pattern;
      logic                full;
   } region_report_type;

   region_report_type pending_reports[$];

   logic [PROT_W-1:0]  exec_bits;
   logic [CRC_W-1:0]   crc_run;
   logic [63:0]        recent_bytes;
   int                 recent_count;
   bit                 seq_seen;
   bit                 scan_fresh;
   bit                 hist_used [TABLE_ENTRIES];
   logic [FIELD_W-1:0] hist_base [TABLE_ENTRIES];
   logic [FIELD_W-1:0] hist_size [TABLE_ENTRIES];
   logic [CRC_W-1:0]   hist_crc [TABLE_ENTRIES];
   logic [PROT_W-1:0]  hist_prot [TABLE_ENTRIES];

   initial begin
      mismatches = 0;
      expected_left = 0;
      results_checked = 0;
   end

   function automatic logic [CRC_W-1:0] crc_add_byte(logic [CRC_W-1:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic clear_model();
      exec_bits = EXEC_MASK_RESET;
      crc_run = CRC_INIT;
      recent_bytes = '0;
      recent_count = 0;
      seq_seen = 0;
      scan_fresh = 1;
      for (int i = 0; i < TABLE_ENTRIES; i++) hist_used[i] = 0;
      pending_reports.delete();
   endtask

   // Fold one accepted byte transaction into the model; queue a report where one is due.
   task automatic predict_byte();
      logic [FIELD_W-1:0] key_base;
      logic [FIELD_W-1:0] key_size;
      logic [CRC_W-1:0]   final_crc;
      int                 hit;
      int                 free_slot;
      region_report_type  rpt;
      key_base = req_region_base & KEY_MASK;
      key_size = req_region_size & KEY_MASK;
      hit = -1;
      free_slot = -1;
      if (req_cmd == CMD_CLEAR) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) hist_used[i] = 0;
         return;
      end
      if (!req_committed || (req_protection & exec_bits) == '0) return;
      if (scan_fresh) begin
         crc_run = CRC_INIT;
         recent_bytes = '0;
         recent_count = 0;
         seq_seen = 0;
         scan_fresh = 0;
      end
      if (recent_count >= 8 && recent_bytes == SEQ_HEAD && req_data_byte == SEQ_TAIL)
         seq_seen = 1;
      recent_bytes = {recent_bytes[55:0], req_data_byte};
      if (recent_count < 8) recent_count++;
      crc_run = crc_add_byte(crc_run, req_data_byte);
      if (!req_last_byte) return;
      scan_fresh = 1;
      final_crc = ~crc_run;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hist_used[i]) begin
            if (hit < 0 && hist_base[i] == key_base && hist_size[i] == key_size) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      rpt.base = key_base;
      rpt.size = key_size;
      rpt.crc = final_crc;
      rpt.pattern = seq_seen;
      rpt.full = 0;
      rpt.old_prot = '0;
      if (hit < 0) begin
         rpt.status = STAT_NEW;
         if (free_slot < 0) begin
            rpt.full = 1;
         end else begin
            hist_used[free_slot] = 1;
            hist_base[free_slot] = key_base;
            hist_size[free_slot] = key_size;
            hist_crc[free_slot] = final_crc;
            hist_prot[free_slot] = req_protection;
         end
      end else begin
         rpt.old_prot = hist_prot[hit];
         if (hist_prot[hit] != req_protection) rpt.status = STAT_PROT_CHANGED;
         else if (hist_crc[hit] != final_crc) rpt.status = STAT_DATA_CHANGED;
         else return;
         hist_crc[hit] = final_crc;
         hist_prot[hit] = req_protection;
      end
      pending_reports.push_back(rpt);
   endtask

   task automatic check_report();
      region_report_type want;
      results_checked++;
      if (pending_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected report: status=%0d base=%h size=%h crc=%h", $realtime,
                     rsp_status, rsp_report_base, rsp_report_size, rsp_region_crc);
         return;
      end
      want = pending_reports.pop_front();
      if (want.status !== rsp_status || want.base !== rsp_report_base ||
          want.size !== rsp_report_size || want.crc !== rsp_region_crc ||
          want.old_prot !== rsp_old_protection || want.pattern !== rsp_pattern_found ||
          want.full !== rsp_table_full) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] report mismatch, expected: status=%0d base=%h size=%h crc=%h",
                     $realtime, want.status, want.base, want.size, want.crc);
            $display("   old_prot=%h pattern=%b full=%b", want.old_prot, want.pattern,
                     want.full);
            $display("   got: status=%0d base=%h size=%h crc=%h old_prot=%h pattern=%b full=%b",
                     rsp_status, rsp_report_base, rsp_report_size, rsp_region_crc,
                     rsp_old_protection, rsp_pattern_found, rsp_table_full);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_EXEC_MASK_IDX)
            exec_bits = csr_pwdata;
         if (req_valid && !req_stall) predict_byte();
         if (rsp_valid && !rsp_stall) check_report();
      end
      expected_left = pending_reports.size();
   end

endmodule

@@ bench/tb_region_change_monitor.sv @@
// Testbench top for the region change monitor: clock, reset, byte and CSR stimulus,
// result-side backpressure and the final verdict.
// Depends on rcm_pkg, region_change_monitor and rcm_checker.
module tb_region_change_monitor;
   import rcm_pkg::*;

   localparam int TABLE_ENTRIES = 64;
   localparam int ADDR_BITS = 48;
   localparam int POOL = 12;
   localparam int MAX_BYTES = 40;
   localparam int SETTLE_CYCLES = TABLE_ENTRIES + 40;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1_500_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = CMD_DATA;
   logic [7:0]            req_data_byte = '0;
   logic [FIELD_W-1:0]    req_region_base = '0;
   logic [FIELD_W-1:0]    req_region_size = '0;
   logic [PROT_W-1:0]     req_protection = '0;
   logic                  req_committed = 1'b0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [FIELD_W-1:0]    rsp_report_base;
   logic [FIELD_W-1:0]    rsp_report_size;
   logic [CRC_W-1:0]      rsp_region_crc;
   logic [PROT_W-1:0]     rsp_old_protection;
   logic                  rsp_pattern_found;
   logic                  rsp_table_full;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int expected_left;
   int results_checked;

   int          cycle_count = 0;
   int          items_sent = 0;
   int          handled_sent = 0;
   int          mask_settings = 0;
   int          hold_asked = 0;
   bit          burst_mode = 0;
   logic [31:0] mask_now = EXEC_MASK_RESET;

   logic [FIELD_W-1:0] pool_base [POOL];
   logic [FIELD_W-1:0] pool_size [POOL];
   logic [PROT_W-1:0]  pool_prot [POOL];
   logic [7:0]         pool_data [POOL][MAX_BYTES];
   int                 pool_len [POOL];

   region_change_monitor #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .ADDR_BITS(ADDR_BITS)
   ) u_top (.*);

   rcm_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .ADDR_BITS(ADDR_BITS)
   ) u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d reports outstanding", cycle_count,
                  expected_left);
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random stall bursts, plus a long hold when the sender asks for one.
   initial begin
      int hold_done;
      int pick;
      int span;
      logic level;
      hold_done = 0;
      forever begin
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            level = 1'b1;
            span = HOLD_CYCLES;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               level = 1'b0;
               span = $urandom_range(1, 20);
            end else if (pick < 85) begin
               level = 1'b1;
               span = $urandom_range(1, 3);
            end else if (pick < 96) begin
               level = 1'b1;
               span = $urandom_range(4, 15);
            end else begin
               level = 1'b1;
               span = $urandom_range(30, 120);
            end
         end
         @(negedge clock) rsp_stall <= level;
         repeat (span - 1) @(negedge clock);
      end
   end

   function automatic logic [FIELD_W-1:0] rand_key();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [7:0] seq_byte(int k);
      return (k < 8) ? SEQ_HEAD[63 - 8*k -: 8] : SEQ_TAIL;
   endfunction

   function automatic logic [31:0] qualifying_prot();
      logic [31:0] p;
      int idx;
      p = $urandom;
      if (mask_now != '0 && (p & mask_now) == '0) begin
         do idx = $urandom_range(0, 31); while (!mask_now[idx]);
         p[idx] = 1'b1;
      end
      return p;
   endfunction

   task automatic idle_gap(int n);
      @(negedge clock) req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic random_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 60) n = 0;
      else if (pick < 90) n = $urandom_range(1, 3);
      else if (pick < 98) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 60);
      if (n > 0) idle_gap(n);
   endtask

   task automatic send_item(cmd_type cmd, logic [7:0] b, logic [FIELD_W-1:0] base,
                            logic [FIELD_W-1:0] size, logic [PROT_W-1:0] prot,
                            logic committed, logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= b;
      req_region_base <= base;
      req_region_size <= size;
      req_protection <= prot;
      req_committed <= committed;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (cmd == CMD_DATA && committed && (prot & mask_now) != '0) handled_sent++;
      random_gap();
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock) csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Drop valid, wait out every expected report, then let a trailing table sweep finish.
   task automatic settle();
      idle_gap(1);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mask(logic [31:0] m);
      settle();
      csr_write({CSR_EXEC_MASK_IDX, 2'b00}, m);
      mask_now = m;
      mask_settings++;
   endtask

   task automatic noise_item();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         send_item(CMD_DATA, $urandom, rand_key(), rand_key(), qualifying_prot(), 1'b0,
                   $urandom_range(0, 1));
      else if (pick < 9)
         send_item(CMD_DATA, $urandom, rand_key(), rand_key(), $urandom & ~mask_now, 1'b1,
                   $urandom_range(0, 1));
      else
         send_item(CMD_CLEAR, $urandom, rand_key(), rand_key(), $urandom,
                   $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   task automatic new_pool_entry(int i);
      int pick;
      int off;
      pick = $urandom_range(0, 19);
      pool_base[i] = (pick == 0) ? '0 : (pick == 1) ? '1 : rand_key();
      pool_size[i] = (pick == 2) ? FIELD_W'(1) : (pick == 3) ? '1 : rand_key();
      if (pool_size[i] == '0) pool_size[i] = FIELD_W'(1);
      pool_prot[i] = qualifying_prot();
      pool_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_BYTES)
                                                : $urandom_range(1, 8);
      for (int j = 0; j < MAX_BYTES; j++) pool_data[i][j] = $urandom;
      if (pool_len[i] >= 9 && $urandom_range(0, 2) == 0) begin
         off = $urandom_range(0, pool_len[i] - 9);
         for (int k = 0; k < 9; k++) pool_data[i][off + k] = seq_byte(k);
         // near miss: spoil one byte of the sequence
         if ($urandom_range(0, 3) == 0)
            pool_data[i][off + $urandom_range(0, 8)] ^= 8'($urandom_range(1, 255));
      end
   endtask

   task automatic scan_region(int i, bit truncate);
      for (int j = 0; j < pool_len[i]; j++) begin
         if ($urandom_range(0, 99) < 8) noise_item();
         send_item(CMD_DATA, pool_data[i][j], pool_base[i], pool_size[i], pool_prot[i],
                   1'b1, (j == pool_len[i] - 1) && !truncate);
      end
   endtask

   task automatic visit(int i);
      int pick;
      logic [31:0] old;
      pick = $urandom_range(0, 99);
      old = pool_prot[i];
      if (pick >= 30 && pick < 55 || pick >= 70 && pick < 80)
         pool_data[i][$urandom_range(0, pool_len[i] - 1)] ^= 8'($urandom_range(1, 255));
      if (pick >= 55 && pick < 80)
         do pool_prot[i] = qualifying_prot(); while (pool_prot[i] == old);
      if (pick >= 80 && pick < 90) new_pool_entry(i);
      if (pick >= 90 && pool_len[i] < MAX_BYTES) pool_len[i]++;
      // a region without its last byte runs on into the next one
      scan_region(i, $urandom_range(0, 99) < 3);
   endtask

   task automatic run_phase(logic [31:0] m, int target, bit pressure);
      int start;
      int visits;
      set_mask(m);
      for (int i = 0; i < POOL; i++) new_pool_entry(i);
      start = handled_sent;
      visits = 0;
      while (handled_sent - start < target) begin
         if (pressure && visits == 20) hold_asked++;
         if (pressure && visits == 80 || $urandom_range(0, 59) == 0) begin
            // hold the sender until every report has drained
            idle_gap(1);
            while (expected_left != 0) @(posedge clock);
         end
         burst_mode = ($urandom_range(0, 4) == 0);
         visit($urandom_range(0, POOL - 1));
         visits++;
      end
      burst_mode = 0;
   endtask

   task automatic directed_checks();
      logic [FIELD_W-1:0] key_c;
      key_c = rand_key();
      send_item(CMD_DATA, 8'h00, '0, FIELD_W'(1), 32'h10, 1'b1, 1'b1);
      send_item(CMD_DATA, 8'h00, '0, FIELD_W'(1), 32'h10, 1'b1, 1'b1);
      send_item(CMD_DATA, 8'hFF, '0, FIELD_W'(1), 32'h10, 1'b1, 1'b1);
      send_item(CMD_DATA, 8'hFF, '0, FIELD_W'(1), 32'h20, 1'b1, 1'b1);
      for (int k = 0; k < 9; k++)
         send_item(CMD_DATA, seq_byte(k), '1, '1, '1, 1'b1, k == 8);
      send_item(CMD_DATA, 8'h5A, '0, FIELD_W'(1), 32'h10, 1'b0, 1'b1);
      send_item(CMD_DATA, 8'h5A, '0, FIELD_W'(1), 32'h0F, 1'b1, 1'b1);
      send_item(CMD_CLEAR, 8'hA5, '1, '1, '1, 1'b1, 1'b1);
      send_item(CMD_DATA, 8'hFF, '0, FIELD_W'(1), 32'h20, 1'b1, 1'b1);
      // clear in the middle of a scan leaves the scan alone
      send_item(CMD_DATA, 8'h12, key_c, FIELD_W'(2), 32'hF0, 1'b1, 1'b0);
      send_item(CMD_CLEAR, 8'h00, '0, '0, '0, 1'b0, 1'b0);
      send_item(CMD_DATA, 8'h34, key_c, FIELD_W'(2), 32'hF0, 1'b1, 1'b1);
   endtask

   // Fill the history table past its end, then revisit a dropped and a stored region.
   task automatic overflow_checks();
      logic [FIELD_W-1:0] first_base;
      logic [FIELD_W-1:0] first_size;
      logic [FIELD_W-1:0] spill_base;
      logic [FIELD_W-1:0] spill_size;
      logic [PROT_W-1:0]  first_prot;
      logic [7:0]         first_byte;
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] size;
      logic [PROT_W-1:0]  prot;
      logic [7:0]         b;
      send_item(CMD_CLEAR, $urandom, rand_key(), rand_key(), $urandom, 1'b1, 1'b1);
      for (int k = 0; k < TABLE_ENTRIES + 2; k++) begin
         base = {32'($urandom), 16'(k)};
         size = rand_key() | FIELD_W'(1);
         prot = qualifying_prot();
         b = $urandom;
         if (k == 0) begin
            first_base = base;
            first_size = size;
            first_prot = prot;
            first_byte = b;
         end
         spill_base = base;
         spill_size = size;
         send_item(CMD_DATA, b, base, size, prot, 1'b1, 1'b1);
      end
      send_item(CMD_DATA, $urandom, spill_base, spill_size, qualifying_prot(), 1'b1, 1'b1);
      send_item(CMD_DATA, first_byte ^ 8'h01, first_base, first_size, first_prot, 1'b1, 1'b1);
      send_item(CMD_CLEAR, $urandom, rand_key(), rand_key(), $urandom, 1'b0, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      directed_checks();
      set_mask('1);
      overflow_checks();
      run_phase('1, 250, 1'b1);
      run_phase(32'h0000_0001, 240, 1'b0);
      run_phase(32'h8000_0000, 240, 1'b0);
      run_phase($urandom | 32'h1, 240, 1'b0);
      run_phase(EXEC_MASK_RESET, 240, 1'b0);
      // nothing is executable: every byte must be ignored
      set_mask('0);
      for (int i = 0; i < 6; i++) begin
         new_pool_entry(i);
         scan_region(i, 1'b0);
      end
      settle();

      $display("Run covered %0d transactions (%0d region bytes handled), %0d reports checked",
               items_sent, handled_sent, results_checked);
      $display("Visited %0d exec_mask settings, including table overflow and clears",
               mask_settings);
      if (mismatches == 0 && expected_left == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ region_change_monitor.f @@
rtl/rcm_pkg.sv
rtl/region_change_monitor.sv
bench/rcm_checker.sv
bench/tb_region_change_monitor.sv
